/* hw/rtl/lapic_tmr_pkg.sv */
// shared types, register offsets and helpers for the local apic timer block
// no dependencies
`default_nettype none

package lapic_tmr_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 32;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register byte offsets
    localparam logic [11:0] OFF_TIMER_ENTRY = 12'h320;
    localparam logic [11:0] OFF_DIVIDE      = 12'h3E0;
    localparam logic [11:0] OFF_INITIAL     = 12'h380;
    localparam logic [11:0] OFF_CURRENT     = 12'h390;
    localparam logic [11:0] OFF_EOI         = 12'h0B0;
    localparam logic [11:0] OFF_SPURIOUS    = 12'h0F0;

    localparam int ENTRY_MASK_BIT     = 16;
    localparam int ENTRY_PERIODIC_BIT = 17;

    localparam logic [31:0] SPURIOUS_RESET = 32'h0000_00FF;
    localparam logic [2:0]  DIV_BY_ONE     = 3'd7;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        timer_fired;
        logic [7:0]  fired_vector;
        logic        irq_pending;
    } t_rsp;

    // compact divide code {bit3, bit1, bit0} to tick divisor
    function automatic logic [7:0] divisor(input logic [2:0] code);
        logic [7:0] d;
        if (code == DIV_BY_ONE) begin
            d = 8'd1;
        end else begin
            d = 8'd2 << code;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lapic_tmr_if.sv */
// valid/ready channel carrying one request or result payload
// payload types come from lapic_tmr_pkg
`default_nettype none

interface lapic_tmr_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lapic_tmr_stage.sv */
// one valid/ready pipeline register stage
// generic over the payload type
`default_nettype none

module lapic_tmr_stage #(
    parameter type t_data = logic
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_data     i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_data     o_data
);
    logic  r_valid;
    t_data r_data;

    // take new data when empty or when the held data leaves this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end
endmodule

`default_nettype wire

/* hw/rtl/lapic_tmr_core.sv */
// timer register file, prescaler and down counter
// uses lapic_tmr_pkg
`default_nettype none

module lapic_tmr_core
    import lapic_tmr_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  t_req      i_req,
    output t_rsp      o_rsp
);
    logic [7:0]             r_vector,   n_vector;
    logic                   r_mask,     n_mask;
    logic                   r_periodic, n_periodic;
    logic [2:0]             r_div,      n_div;
    logic [COUNT_WIDTH-1:0] r_init,     n_init;
    logic [COUNT_WIDTH-1:0] r_cur,      n_cur;
    logic [6:0]             r_pre,      n_pre;
    logic [31:0]            r_spur,     n_spur;
    logic                   r_pend,     n_pend;

    logic [COUNT_WIDTH-1:0] dec;

    assign dec = r_cur - COUNT_WIDTH'(1);

    always_comb begin
        n_vector   = r_vector;
        n_mask     = r_mask;
        n_periodic = r_periodic;
        n_div      = r_div;
        n_init     = r_init;
        n_cur      = r_cur;
        n_pre      = r_pre;
        n_spur     = r_spur;
        n_pend     = r_pend;
        o_rsp      = '0;

        unique case (i_req.operation)
            OP_TICK: begin
                if (r_cur != '0) begin
                    if (({1'b0, r_pre} + 8'd1) >= divisor(r_div)) begin
                        n_pre = '0;
                        n_cur = dec;
                        if (dec == '0) begin
                            if (!r_mask) begin
                                o_rsp.timer_fired  = 1'b1;
                                o_rsp.fired_vector = r_vector;
                                n_pend             = 1'b1;
                            end
                            if (r_periodic) begin
                                n_cur = r_init;
                            end
                        end
                    end else begin
                        n_pre = r_pre + 7'd1;
                    end
                end
            end
            OP_READ: begin
                unique case (i_req.reg_offset)
                    OFF_TIMER_ENTRY: o_rsp.read_data =
                        {14'd0, r_periodic, r_mask, 8'd0, r_vector};
                    OFF_DIVIDE:   o_rsp.read_data = {28'd0, r_div[2], 1'b0, r_div[1:0]};
                    OFF_INITIAL:  o_rsp.read_data = 32'(r_init);
                    OFF_CURRENT:  o_rsp.read_data = 32'(r_cur);
                    OFF_SPURIOUS: o_rsp.read_data = r_spur;
                    default:      o_rsp.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (i_req.reg_offset)
                    OFF_TIMER_ENTRY: begin
                        n_vector   = i_req.write_data[7:0];
                        n_mask     = i_req.write_data[ENTRY_MASK_BIT];
                        n_periodic = i_req.write_data[ENTRY_PERIODIC_BIT];
                    end
                    OFF_DIVIDE: begin
                        n_div = {i_req.write_data[3], i_req.write_data[1:0]};
                    end
                    OFF_INITIAL: begin
                        n_init = i_req.write_data[COUNT_WIDTH-1:0];
                        n_cur  = i_req.write_data[COUNT_WIDTH-1:0];
                        n_pre  = '0;
                    end
                    OFF_SPURIOUS: n_spur = i_req.write_data;
                    OFF_EOI:      n_pend = 1'b0;
                    default: ;
                endcase
            end
            default: ;
        endcase

        o_rsp.irq_pending = n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector   <= '0;
            r_mask     <= 1'b1;
            r_periodic <= 1'b0;
            r_div      <= '0;
            r_init     <= '0;
            r_cur      <= '0;
            r_pre      <= '0;
            r_spur     <= SPURIOUS_RESET;
            r_pend     <= 1'b0;
        end else if (i_fire) begin
            r_vector   <= n_vector;
            r_mask     <= n_mask;
            r_periodic <= n_periodic;
            r_div      <= n_div;
            r_init     <= n_init;
            r_cur      <= n_cur;
            r_pre      <= n_pre;
            r_spur     <= n_spur;
            r_pend     <= n_pend;
        end
    end
endmodule

`default_nettype wire

/* hw/rtl/local_apic_timer_registers.sv */
// top level of the local apic timer block
// uses lapic_tmr_pkg, lapic_tmr_if, lapic_tmr_stage and lapic_tmr_core
`default_nettype none

// Timer section of a local interrupt controller. Each request is a timer
// clock tick, a register read or a register write, and each gives exactly
// one result carrying read data, a fired strobe with its vector, and the
// pending flag after the request. Registers: timer entry (0x320), divide
// configuration (0x3E0), initial count (0x380), current count (0x390, read
// only), spurious vector (0x0F0) and end-of-interrupt (0x0B0, write only).
// Rate is one request per cycle while the output side takes results. The
// request lands in an input register, the register file and counter update
// in one pass of short logic, and the result lands in an output register.
// While a result waits in the output register, the input register takes
// one more request and then holds the input off until the waiting result
// leaves.
module local_apic_timer_registers
    import lapic_tmr_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    lapic_tmr_if.sink          i_req,
    lapic_tmr_if.source        o_rsp
);
    // input register to core
    logic s_req_valid;
    logic s_req_ready;
    t_req s_req;

    // core to output register
    t_rsp s_rsp;
    logic s_rsp_ready;
    logic s_fire;

    lapic_tmr_stage #(
        .t_data (t_req)
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_data  (i_req.payload),
        .o_valid (s_req_valid),
        .i_ready (s_req_ready),
        .o_data  (s_req)
    );

    // the core commits a request only when its result has a place to go
    assign s_fire      = s_req_valid && s_rsp_ready;
    assign s_req_ready = s_rsp_ready;

    lapic_tmr_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s_fire),
        .i_req   (s_req),
        .o_rsp   (s_rsp)
    );

    lapic_tmr_stage #(
        .t_data (t_rsp)
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_req_valid),
        .o_ready (s_rsp_ready),
        .i_data  (s_rsp),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (o_rsp.payload)
    );
endmodule

`default_nettype wire

/* hw/rtl/lapic_tmr_chk.sv */
// port-level checks for the local apic timer block, bound to the top level
// does not use lapic_tmr_pkg; its ports are plain logic vectors
`default_nettype none

module lapic_tmr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [31:0] i_read_data,
    input wire logic        i_timer_fired,
    input wire logic [7:0]  i_fired_vector,
    input wire logic        i_irq_pending
);
    // a vector only shows together with a fire strobe
    a_vector_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_timer_fired) |-> (i_fired_vector == 8'd0))
        else $error("vector shown without fire");

    // a fire always leaves the interrupt pending
    a_fire_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_timer_fired) |-> i_irq_pending)
        else $error("fire without pending flag");

    // a tick result never carries read data at the same time as a fire
    a_fire_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_timer_fired) |-> (i_read_data == 32'd0))
        else $error("fire result carries read data");

    // a stalled result holds its read data, fire strobe and pending flag
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_read_data)
            && $stable(i_timer_fired) && $stable(i_irq_pending)))
        else $error("stalled result changed");
endmodule

bind local_apic_timer_registers lapic_tmr_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_read_data    (o_rsp.payload.read_data),
    .i_timer_fired  (o_rsp.payload.timer_fired),
    .i_fired_vector (o_rsp.payload.fired_vector),
    .i_irq_pending  (o_rsp.payload.irq_pending)
);

`default_nettype wire
